// File: hw/rtl/array_byteswap_column_to_row_reorder_core_defines.svh
// Assertion macros for the array reorder core.
// Included by the top level; no other dependencies.
`ifndef ARRAY_BYTESWAP_COLUMN_TO_ROW_REORDER_CORE_DEFINES_SVH
`define ARRAY_BYTESWAP_COLUMN_TO_ROW_REORDER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define ABRR_AST_HOLDS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ABRR_AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/abrr_pkg.sv
// Shared constants, codes and types for the array reorder core.
// No dependencies; imported by abrr_geom and the top level.
package abrr_pkg;

  localparam int DEF_MAX_AXES    = 5;
  localparam int DEF_STORE_DEPTH = 4096;

  localparam int DATA_W = 64;
  localparam int LEN_W  = 13;
  localparam int IDX_W  = 3;
  localparam int EB_W   = 4;
  localparam int STAT_W = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ELEM_BYTES = 3'd0;
  localparam logic [IDX_W-1:0] REG_SWAP       = 3'd1;
  localparam logic [IDX_W-1:0] REG_COL_MAJOR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_AXIS0      = 3'd3;

  // item operations
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EXTRA     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_TRUNC     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EXHAUST   = 3'd4;

  typedef struct packed {
    logic clear;    // new array: zero the odometer
    logic advance;  // fetch accepted: step the odometer
  } geom_ctl_t;

endpackage

// File: hw/rtl/abrr_geom.sv
// Array geometry: axis lengths, strides, element count and the gather odometer.
// Depends on abrr_pkg. Strides and count are rebuilt by a sequencer after each
// configuration write, one axis per cycle with one multiplier per product.
module abrr_geom #(
  parameter int MAX_AXES    = abrr_pkg::DEF_MAX_AXES,
  parameter int STORE_DEPTH = abrr_pkg::DEF_STORE_DEPTH,
  localparam int CW  = $clog2(STORE_DEPTH + 2),
  localparam int AXW = $clog2(MAX_AXES),
  localparam int SRW = CW + AXW
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [abrr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [abrr_pkg::LEN_W-1:0]     cfg_data,
  input  abrr_pkg::geom_ctl_t            ctl,
  output logic                           busy,
  output logic [CW-1:0]                  count,
  output logic [SRW-1:0]                 src
);
  import abrr_pkg::*;

  localparam int SW = $clog2(MAX_AXES + 1);
  localparam int MW = CW + LEN_W;
  localparam logic [CW-1:0] SAT_V = CW'(STORE_DEPTH + 1);

  logic [LEN_W-1:0] len_r    [MAX_AXES];
  logic [LEN_W-1:0] pos_r    [MAX_AXES];
  logic [CW-1:0]    t_r      [MAX_AXES];  // position times stride, saturated
  logic [CW-1:0]    stride_r [MAX_AXES];
  logic [CW-1:0]    count_r;
  logic             busy_r;
  logic [SW-1:0]    step_r;
  logic [SRW-1:0]   src_r;

  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] cur_pos;
  logic [CW-1:0]    cur_str;
  logic [MW-1:0]    smul;
  logic [MW-1:0]    tmul;
  logic [CW-1:0]    smul_sat;
  logic [CW-1:0]    tmul_sat;

  logic [MAX_AXES-1:0] wrap;
  logic [MAX_AXES-1:0] carry;
  logic [LEN_W-1:0]    pos_inc [MAX_AXES];
  logic [CW-1:0]       t_inc   [MAX_AXES];
  logic [SRW-1:0]      src_sum;
  logic [IDX_W-1:0]    axis_sel;

  assign busy  = busy_r;
  assign count = count_r;
  assign src   = src_r;
  assign axis_sel = cfg_index - REG_AXIS0;

  // pick the axis the sequencer works on this cycle
  always_comb begin
    cur_len = '0;
    cur_pos = '0;
    cur_str = '0;
    for (int j = 0; j < MAX_AXES; j++) begin
      if (step_r == SW'(j)) begin
        cur_len = len_r[j];
        cur_pos = pos_r[j];
        cur_str = stride_r[j];
      end
    end
    smul = MW'(cur_str) * MW'(cur_len);
    tmul = MW'(cur_pos) * MW'(cur_str);
    smul_sat = (smul > MW'(SAT_V)) ? SAT_V : smul[CW-1:0];
    tmul_sat = (tmul > MW'(SAT_V)) ? SAT_V : tmul[CW-1:0];
  end

  // odometer: last axis fastest, carry moves towards axis 0
  always_comb begin
    logic [LEN_W:0] p1;
    logic [CW:0]    tadd;
    for (int j = 0; j < MAX_AXES; j++) begin
      p1         = {1'b0, pos_r[j]} + {{LEN_W{1'b0}}, 1'b1};
      wrap[j]    = p1 >= {1'b0, len_r[j]};
      pos_inc[j] = p1[LEN_W-1:0];
      tadd       = {1'b0, t_r[j]} + {1'b0, stride_r[j]};
      t_inc[j]   = (tadd > {1'b0, SAT_V}) ? SAT_V : tadd[CW-1:0];
    end
    carry[MAX_AXES-1] = 1'b1;
    for (int j = MAX_AXES - 2; j >= 0; j--) begin
      carry[j] = carry[j+1] & wrap[j+1];
    end
    src_sum = '0;
    for (int j = 0; j < MAX_AXES; j++) begin
      src_sum = src_sum + SRW'(t_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_AXES; j++) begin
        len_r[j]    <= LEN_W'(1);
        pos_r[j]    <= '0;
        t_r[j]      <= '0;
        stride_r[j] <= CW'(1);
      end
      count_r <= CW'(1);
      busy_r  <= 1'b0;
      step_r  <= '0;
      src_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index >= REG_AXIS0)) begin
        for (int j = 0; j < MAX_AXES; j++) begin
          if (int'(axis_sel) == j) begin
            len_r[j] <= cfg_data;
          end
        end
      end

      // rebuild strides, count and partial offsets after any write
      if (cfg_we) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == SW'(MAX_AXES)) begin
          busy_r <= 1'b0;
        end else begin
          for (int j = 0; j < MAX_AXES; j++) begin
            if (step_r == SW'(j)) begin
              t_r[j] <= tmul_sat;
            end
          end
          for (int j = 1; j < MAX_AXES; j++) begin
            if (step_r == SW'(j - 1)) begin
              stride_r[j] <= smul_sat;
            end
          end
          if (step_r == SW'(MAX_AXES - 1)) begin
            count_r <= smul_sat;
          end
          step_r <= step_r + 1'b1;
        end
      end

      if (ctl.clear) begin
        for (int j = 0; j < MAX_AXES; j++) begin
          pos_r[j] <= '0;
          t_r[j]   <= '0;
        end
        src_r <= '0;
      end else begin
        if (ctl.advance) begin
          for (int j = 0; j < MAX_AXES; j++) begin
            if (carry[j]) begin
              pos_r[j] <= wrap[j] ? '0 : pos_inc[j];
              t_r[j]   <= wrap[j] ? '0 : t_inc[j];
            end
          end
        end
        src_r <= src_sum;
      end
    end
  end

endmodule

// File: hw/rtl/array_byteswap_column_to_row_reorder_core.sv
// Array reorder core: element store, push/fetch control and result register.
// Depends on abrr_pkg, abrr_geom and the assertion macro header.
//
// Usage: items arrive on in_* (valid/ready). op = push writes one element,
// trimmed to element_bytes bytes and optionally byte-reversed, at the next
// free store entry; first on a push starts a new array. op = fetch returns
// the next element in row-major order, gathered through the axis odometer
// when column_major is set. Every item gives exactly one result on out_*.
// A push or a failed fetch gives its result in the cycle after acceptance;
// a good fetch reads the store into a read register, then loads the output
// register, taking no new item meanwhile; one push per cycle when unstalled.
// A result waits in the output register while out_ready is low; a new item
// is taken once that register is empty or being emptied in the same cycle.
// After each cfg_* write, in_ready stays low while the strides and element
// count are rebuilt, one axis per cycle.
// Reset clears the counters and odometer and sets every axis length to 1;
// the store itself is not cleared and needs no clearing pass.
`include "array_byteswap_column_to_row_reorder_core_defines.svh"

module array_byteswap_column_to_row_reorder_core #(
  parameter int MAX_AXES    = abrr_pkg::DEF_MAX_AXES,
  parameter int STORE_DEPTH = abrr_pkg::DEF_STORE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [abrr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [abrr_pkg::LEN_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic                            in_first,
  input  logic [abrr_pkg::DATA_W-1:0]     in_element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [abrr_pkg::DATA_W-1:0]     out_data,
  output logic                            out_last,
  output logic [abrr_pkg::STAT_W-1:0]     out_status
);
  import abrr_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CW  = $clog2(STORE_DEPTH + 2);
  localparam int AXW = $clog2(MAX_AXES);
  localparam int SRW = CW + AXW;
  localparam logic [CW-1:0] DEP_V = CW'(STORE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  function automatic logic [DATA_W-1:0] prep_elem(input logic [DATA_W-1:0] v,
                                                  input logic [EB_W-1:0]   n,
                                                  input logic              sw);
    logic [DATA_W-1:0] r;
    logic [2:0]        bi;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      bi = 3'(n - 4'd1 - 4'(i));
      if (4'(i) < n) begin
        r[8*i +: 8] = sw ? v[8*bi +: 8] : v[8*i +: 8];
      end
    end
    return r;
  endfunction

  logic [EB_W-1:0]   ebytes_r;
  logic              swap_r;
  logic              colmaj_r;
  logic [CW-1:0]     loaded_r;
  logic [CW-1:0]     emitted_r;
  logic              state_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;
  logic [STAT_W-1:0] out_status_r;
  logic              rd_hit_r;
  logic              rd_last_r;
  logic [DATA_W-1:0] mem_rdata_r;
  logic [DATA_W-1:0] store_mem [STORE_DEPTH];

  logic              geo_busy;
  logic [CW-1:0]     geo_count;
  logic [SRW-1:0]    geo_src;
  geom_ctl_t         geo_ctl;

  logic              in_acc;
  logic              too_large;
  logic [CW-1:0]     load_base;
  logic              push_ok;
  logic              fetch_ok;
  logic [SRW-1:0]    src_sel;
  logic [EB_W-1:0]   esize;
  logic [CW-1:0]     loaded_nxt;
  logic [CW-1:0]     emitted_nxt;
  logic [STAT_W-1:0] imm_status;
  logic              out_take;

  abrr_geom #(
    .MAX_AXES    (MAX_AXES),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (geo_ctl),
    .busy      (geo_busy),
    .count     (geo_count),
    .src       (geo_src)
  );

  assign out_take = out_valid_r && out_ready;
  assign in_ready = (state_r == ST_IDLE) && !geo_busy && !cfg_we &&
                    (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    if (ebytes_r == '0) begin
      esize = EB_W'(1);
    end else if (ebytes_r > EB_W'(8)) begin
      esize = EB_W'(8);
    end else begin
      esize = ebytes_r;
    end
    too_large = geo_count > DEP_V;
    load_base = in_first ? '0 : loaded_r;
    push_ok   = !too_large && (load_base < geo_count);
    fetch_ok  = !too_large && (emitted_r < geo_count) && (loaded_r >= geo_count);
    src_sel   = colmaj_r ? geo_src : SRW'(emitted_r);

    geo_ctl.clear   = in_acc && (in_op == OP_PUSH) && in_first;
    geo_ctl.advance = in_acc && (in_op == OP_FETCH) && fetch_ok;

    loaded_nxt  = loaded_r;
    emitted_nxt = emitted_r;
    imm_status  = STAT_OK;
    if (in_op == OP_PUSH) begin
      if (in_first) begin
        emitted_nxt = '0;
      end
      loaded_nxt = push_ok ? load_base + 1'b1 : load_base;
      if (too_large) begin
        imm_status = STAT_TOO_LARGE;
      end else if (!push_ok) begin
        imm_status = STAT_EXTRA;
      end
    end else begin
      if (fetch_ok) begin
        emitted_nxt = emitted_r + 1'b1;
      end
      if (too_large) begin
        imm_status = STAT_TOO_LARGE;
      end else if (emitted_r >= geo_count) begin
        imm_status = STAT_EXHAUST;
      end else if (loaded_r < geo_count) begin
        imm_status = STAT_TRUNC;
      end
    end
  end

  // store: one write or one read per item, read data registered
  always_ff @(posedge clk) begin
    if (in_acc && (in_op == OP_PUSH) && push_ok) begin
      store_mem[load_base[AW-1:0]] <= prep_elem(in_element, esize, swap_r);
    end
    if (geo_ctl.advance) begin
      mem_rdata_r <= store_mem[src_sel[AW-1:0]];
      rd_hit_r    <= src_sel < SRW'(loaded_r);
      rd_last_r   <= emitted_nxt == geo_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ebytes_r    <= EB_W'(1);
      swap_r      <= 1'b0;
      colmaj_r    <= 1'b0;
      loaded_r    <= '0;
      emitted_r   <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ELEM_BYTES: ebytes_r <= cfg_data[EB_W-1:0];
          REG_SWAP:       swap_r   <= cfg_data[0];
          REG_COL_MAJOR:  colmaj_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        loaded_r  <= loaded_nxt;
        emitted_r <= emitted_nxt;
      end
      if (state_r == ST_READ) begin
        state_r     <= ST_IDLE;
        out_valid_r <= 1'b1;
      end else if (in_acc && !geo_ctl.advance) begin
        out_valid_r <= 1'b1;
      end else begin
        if (geo_ctl.advance) begin
          state_r <= ST_READ;
        end
        if (out_take) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // result payload: immediate results on accept, gathered data after the read
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      out_data_r   <= rd_hit_r ? mem_rdata_r : '0;
      out_last_r   <= rd_last_r;
      out_status_r <= STAT_OK;
    end else if (in_acc && !geo_ctl.advance) begin
      out_data_r   <= '0;
      out_last_r   <= 1'b0;
      out_status_r <= imm_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  `ABRR_AST_HOLDS(a_loaded_in_store, clk, rst_n, loaded_r <= DEP_V, "loaded count beyond store")
  `ABRR_AST_HOLDS(a_emit_le_load, clk, rst_n, emitted_r <= loaded_r, "emitted more than loaded")
  `ABRR_AST_NEXT(a_read_result, clk, rst_n, state_r == ST_READ, (state_r == ST_IDLE) && out_valid_r, "fetch result lost")

endmodule

// File: tb/sv/tb_array_byteswap_column_to_row_reorder_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the array reorder core: drives push and fetch items,
// keeps its own model of the store, counters and odometer, and checks each result.
// Depends on abrr_pkg and array_byteswap_column_to_row_reorder_core.
module tb_array_byteswap_column_to_row_reorder_core;
  import abrr_pkg::*;

  localparam int AXES         = DEF_MAX_AXES;
  localparam int DEPTH        = DEF_STORE_DEPTH;
  localparam int RANDOM_ITEMS = 540;

  typedef int axis_lens_t [AXES];

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
    logic [STAT_W-1:0] status;
  } reorder_result_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [LEN_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic              in_op      = OP_PUSH;
  logic              in_first   = 1'b0;
  logic [DATA_W-1:0] in_element = '0;
  logic              out_valid;
  logic              out_ready  = 1'b1;
  logic [DATA_W-1:0] out_data;
  logic              out_last;
  logic [STAT_W-1:0] out_status;

  // shadow copy of the block's state and registers
  logic [DATA_W-1:0] shadow_store [DEPTH];
  int                shadow_loaded  = 0;
  int                shadow_emitted = 0;
  int                shadow_pos [AXES] = '{default: 0};
  int                shadow_len [AXES] = '{default: 1};
  int                shadow_ebytes  = 1;
  bit                shadow_swap    = 1'b0;
  bit                shadow_colmaj  = 1'b0;

  reorder_result_t   expected_results [$];
  int                fail_count = 0;
  int                items_sent = 0;
  bit                idling     = 1'b1;

  array_byteswap_column_to_row_reorder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_first   (in_first),
    .in_element (in_element),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .out_last   (out_last),
    .out_status (out_status)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Product of axis lengths, saturated one above the store depth.
  function automatic int array_size();
    longint c;
    c = 1;
    foreach (shadow_len[j]) if (shadow_len[j] == 0) return 0;
    foreach (shadow_len[j]) begin
      c = c * shadow_len[j];
      if (c > DEPTH) c = DEPTH + 1;
    end
    return int'(c);
  endfunction

  function automatic logic [DATA_W-1:0] trim_and_swap(logic [DATA_W-1:0] raw);
    int                n;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] r;
    n = (shadow_ebytes == 0) ? 1 : (shadow_ebytes > 8) ? 8 : shadow_ebytes;
    v = raw;
    r = '0;
    if (n < 8) v = raw & ((64'd1 << (8 * n)) - 64'd1);
    if (!shadow_swap || n < 2) return v;
    for (int i = 0; i < n; i++) r[8*(n-1-i) +: 8] = v[8*i +: 8];
    return r;
  endfunction

  function automatic reorder_result_t predict_result(logic op, logic first,
                                                     logic [DATA_W-1:0] raw);
    reorder_result_t r;
    int              total;
    longint          src;
    longint          stride;
    bit              carry;
    r = '0;
    if (op == OP_PUSH) begin
      if (first) begin
        shadow_loaded  = 0;
        shadow_emitted = 0;
        foreach (shadow_pos[j]) shadow_pos[j] = 0;
      end
      total = array_size();
      if (total > DEPTH) r.status = STAT_TOO_LARGE;
      else if (shadow_loaded >= total) r.status = STAT_EXTRA;
      else begin
        shadow_store[shadow_loaded] = trim_and_swap(raw);
        shadow_loaded++;
      end
    end else begin
      total = array_size();
      if (total > DEPTH) r.status = STAT_TOO_LARGE;
      else if (shadow_emitted >= total) r.status = STAT_EXHAUST;
      else if (shadow_loaded < total) r.status = STAT_TRUNC;
      else begin
        src = shadow_emitted;
        if (shadow_colmaj) begin
          src    = 0;
          stride = 1;
          for (int j = 0; j < AXES; j++) begin
            src    = src + longint'(shadow_pos[j]) * stride;
            stride = stride * shadow_len[j];
          end
        end
        // a gather past the loaded part returns zero
        if (src < shadow_loaded) r.data = shadow_store[src];
        shadow_emitted++;
        carry = 1'b1;
        for (int j = AXES - 1; j >= 0; j--) begin
          if (carry) begin
            shadow_pos[j]++;
            if (shadow_pos[j] < shadow_len[j]) carry = 1'b0;
            else shadow_pos[j] = 0;
          end
        end
        if (shadow_emitted == total) r.last = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void log_mismatch(string why, reorder_result_t got,
                                       reorder_result_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: got data=%h last=%b status=%0d, expected data=%h last=%b status=%0d",
               $time, why, got.data, got.last, got.status,
               want.data, want.last, want.status);
  endfunction

  always @(posedge clk) begin : result_monitor
    reorder_result_t got;
    reorder_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{data: out_data, last: out_last, status: out_status};
      if (expected_results.size() == 0) begin
        log_mismatch("result with no item outstanding", got, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.data !== want.data || got.last !== want.last ||
            got.status !== want.status)
          log_mismatch("result mismatch", got, want);
      end
    end
    if (rst_n && in_valid && in_ready)
      expected_results.insert(expected_results.size(),
                              predict_result(in_op, in_first, in_element));
  end

  initial begin : result_stall
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[LEN_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ELEM_BYTES: shadow_ebytes = value & 15;
      REG_SWAP:       shadow_swap   = value[0];
      REG_COL_MAJOR:  shadow_colmaj = value[0];
      default: begin
        if (int'(idx) - int'(REG_AXIS0) < AXES)
          shadow_len[int'(idx) - int'(REG_AXIS0)] = value & 32'h1FFF;
      end
    endcase
  endtask

  task automatic set_shape(int ebytes, bit swap, bit colmaj, axis_lens_t lens);
    write_reg(REG_ELEM_BYTES, ebytes);
    write_reg(REG_SWAP, swap);
    write_reg(REG_COL_MAJOR, colmaj);
    foreach (lens[j]) write_reg(REG_AXIS0 + IDX_W'(j), lens[j]);
  endtask

  task automatic send_item(logic op, logic first, logic [DATA_W-1:0] elem);
    int gap;
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_first   <= first;
    in_element <= elem;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic axis_lens_t random_shape();
    axis_lens_t l;
    int         prod;
    int         kind;
    prod = 1;
    kind = $urandom_range(0, 19);
    foreach (l[j]) begin
      l[j] = 1;
      if ($urandom_range(0, 1) && prod < 12) begin
        l[j] = $urandom_range(2, 4);
        prod = prod * l[j];
      end
    end
    case (kind)
      0: l[$urandom_range(0, AXES - 1)] = 0;
      1: l[$urandom_range(0, AXES - 1)] = DEPTH + 1;
      2: l[$urandom_range(0, AXES - 1)] = 8191;
      3: begin
        l[0]        = DEPTH;
        l[AXES - 1] = 2;
      end
      default: ;
    endcase
    return l;
  endfunction

  task automatic load_array(int n);
    for (int i = 0; i < n; i++) begin
      send_item(OP_PUSH, i == 0, random_element());
      if ($urandom_range(0, 9) == 0)
        send_item(OP_FETCH, $urandom_range(0, 1), random_element());
    end
  endtask

  task automatic fetch_run(int n);
    for (int i = 0; i < n; i++) send_item(OP_FETCH, $urandom_range(0, 1), random_element());
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++)
      send_item($urandom_range(0, 1), $urandom_range(0, 3) == 0, random_element());
  endtask

  task automatic test_reset_state();
    send_item(OP_PUSH, 1'b1, '1);
    send_item(OP_FETCH, 1'b0, '0);
    send_item(OP_FETCH, 1'b0, '0);
    send_item(OP_PUSH, 1'b0, 64'h5A);
    send_item(OP_FETCH, 1'b1, '1);
    drain_results();
  endtask

  task automatic test_byte_order();
    set_shape(8, 1'b1, 1'b0, '{1, 1, 1, 1, 2});
    send_item(OP_PUSH, 1'b1, 64'h0123_4567_89AB_CDEF);
    send_item(OP_FETCH, 1'b0, '0);
    send_item(OP_PUSH, 1'b0, 64'h8000_0000_0000_0001);
    send_item(OP_FETCH, 1'b0, '0);
    send_item(OP_FETCH, 1'b0, '0);
    drain_results();
    set_shape(3, 1'b1, 1'b0, '{1, 1, 1, 1, 1});
    send_item(OP_PUSH, 1'b1, 64'hFFEE_DDCC_BBAA_9988);
    send_item(OP_FETCH, 1'b0, '0);
    drain_results();
  endtask

  task automatic test_size_limits();
    set_shape(15, 1'b0, 1'b0, '{8191, 1, 1, 1, 1});
    send_item(OP_PUSH, 1'b1, '1);
    send_item(OP_FETCH, 1'b0, '0);
    drain_results();
    set_shape(0, 1'b0, 1'b0, '{1, 1, 0, 1, 1});
    send_item(OP_PUSH, 1'b1, '1);
    send_item(OP_FETCH, 1'b0, '0);
    drain_results();
  endtask

  task automatic test_column_gather();
    set_shape(2, 1'b1, 1'b1, '{2, 1, 1, 1, 3});
    for (int i = 0; i < 6; i++) send_item(OP_PUSH, i == 0, {$urandom, $urandom});
    fetch_run(6);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int         stop_at;
    int         n;
    int         kind;
    axis_lens_t lens;
    axis_lens_t flipped;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      idling = ($urandom_range(0, 3) != 0);
      lens   = random_shape();
      set_shape($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1), lens);
      n    = array_size();
      kind = $urandom_range(0, 9);
      if (n == 0 || n > DEPTH || kind >= 8) begin
        send_noise($urandom_range(1, 12));
      end else begin
        load_array(n);
        if (kind < 6) begin
          fetch_run(n + $urandom_range(0, 1));
        end else begin
          // reshape part way through, keeping counters and odometer
          fetch_run($urandom_range(0, n));
          drain_results();
          foreach (flipped[j]) flipped[j] = lens[AXES - 1 - j];
          if ($urandom_range(0, 1)) lens = flipped;
          else lens = random_shape();
          write_reg(REG_COL_MAJOR, $urandom_range(0, 1));
          foreach (lens[j]) write_reg(REG_AXIS0 + IDX_W'(j), lens[j]);
          fetch_run(n + 2);
        end
      end
      drain_results();
    end
  endtask

  task automatic test_back_to_back();
    int n;
    idling = 1'b0;
    set_shape(8, 1'b0, 1'b1, '{2, 2, 2, 2, 4});
    n = array_size();
    for (int i = 0; i < n; i++) send_item(OP_PUSH, i == 0, random_element());
    fetch_run(n + 1);
    send_item(OP_PUSH, 1'b0, '1);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_byte_order();
    test_size_limits();
    test_column_gather();
    test_random_traffic();
    test_back_to_back();
    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
